@@ rtl/plob_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package plob_pkg;

    localparam int PRICE_W = 32;
    localparam int VOL_W   = 24;
    localparam int NET_W   = 25;
    localparam int TICK_W  = 20;
    localparam int RANGE_W = 8;
    localparam int BLEN_W  = 13;
    localparam int CFG_W   = 20;
    localparam int IDX_W   = 12;

    // numerator 2*(p - lower) + tick, divisor 2*tick
    localparam int DIV_W = 36;
    localparam int DEN_W = TICK_W + 1;

    localparam logic [1:0] MODE_HEADER = 2'd0;
    localparam logic [1:0] MODE_LEVEL  = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    localparam logic [1:0] REG_TICK   = 2'd0;
    localparam logic [1:0] REG_RANGE  = 2'd1;
    localparam logic [1:0] REG_LENGTH = 2'd2;

    localparam logic KIND_COMMIT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

endpackage

`default_nettype wire

@@ rtl/plob_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module plob_div
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic signed [plob_pkg::DIV_W-1:0]  num,
    input  wire logic        [plob_pkg::DEN_W-1:0]  den,
    output logic                                     done,
    output logic signed [plob_pkg::DIV_W-1:0]       quo
);

    localparam int DW  = plob_pkg::DIV_W;
    localparam int NW  = plob_pkg::DEN_W;
    localparam int CNW = $clog2(DW);

    logic            run_reg;
    logic [CNW-1:0]  cnt_reg;
    logic            neg_reg;
    logic [DW-1:0]   mag_reg;
    logic [NW:0]     rem_reg;
    logic [NW-1:0]   den_reg;
    logic            done_reg;

    logic [NW:0]     rem_sh;
    logic            ge;
    logic [NW:0]     rem_nx;

    // one quotient bit per cycle, restoring, on magnitudes
    assign rem_sh = {rem_reg[NW-1:0], mag_reg[DW-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};
    assign rem_nx = ge ? rem_sh - {1'b0, den_reg} : rem_sh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            neg_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
                neg_reg <= num[DW-1];
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNW'(DW - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg <= num[DW-1] ? DW'(-num) : DW'(num);
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            mag_reg <= {mag_reg[DW-2:0], ge};
            rem_reg <= rem_nx;
        end
    end

    assign done = done_reg;
    assign quo  = neg_reg ? -$signed(mag_reg) : $signed(mag_reg);

endmodule

`default_nettype wire

@@ rtl/price_ladder_order_book_update_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Bid/ask price ladder builder. After reset both ladders are swept to zero,
// one entry per cycle over all BOOK_DEPTH entries; no request is taken meanwhile.
// Header and non-final level requests are taken without leaving the idle
// state; a read passes through a read state and a result state. A final level
// commits the snapshot: four tick-index divisions for the refresh range ends,
// then the clearing of the refresh ranges, then per level up to two
// divisions. All divisions share one bit-serial divider.
// Configuration must be written only while the block is idle; the block
// itself does not enforce this.
module price_ladder_order_book_update_unit
#(
    parameter int MAX_LEVELS = 32,
    parameter int BOOK_DEPTH = 4096
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [1:0]                            cfg_index,
    input  wire logic [plob_pkg::CFG_W-1:0]            cfg_data,
    input  wire logic                                  req_valid,
    output logic                                       req_stall,
    input  wire logic [1:0]                            mode,
    input  wire logic [plob_pkg::PRICE_W-1:0]          lower_limit,
    input  wire logic [plob_pkg::PRICE_W-1:0]          upper_limit,
    input  wire logic [plob_pkg::PRICE_W-1:0]          bid_price,
    input  wire logic [plob_pkg::PRICE_W-1:0]          ask_price,
    input  wire logic [plob_pkg::VOL_W-1:0]            bid_volume,
    input  wire logic [plob_pkg::VOL_W-1:0]            ask_volume,
    input  wire logic [plob_pkg::VOL_W-1:0]            bid_implied,
    input  wire logic [plob_pkg::VOL_W-1:0]            ask_implied,
    input  wire logic                                  last_level,
    input  wire logic                                  read_side,
    input  wire logic [plob_pkg::IDX_W-1:0]            read_index,
    output logic                                       rsp_valid,
    input  wire logic                                  rsp_stall,
    output logic                                       kind,
    output logic                                       limit_stop,
    output logic signed [plob_pkg::NET_W-1:0]          entry_volume,
    output logic                                       index_overflow
);

    localparam int PW  = plob_pkg::PRICE_W;
    localparam int NTW = plob_pkg::NET_W;
    localparam int TW  = plob_pkg::TICK_W;
    localparam int DW  = plob_pkg::DIV_W;
    localparam int AW  = $clog2(BOOK_DEPTH);
    localparam int LW  = $clog2(BOOK_DEPTH + 1);
    localparam int CW  = $clog2(MAX_LEVELS + 1);
    localparam int LAW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int RTW = plob_pkg::RANGE_W + TW;

    typedef enum logic [15:0] {
        ST_INIT    = 16'h0001,
        ST_IDLE    = 16'h0002,
        ST_RD      = 16'h0004,
        ST_PREP    = 16'h0008,
        ST_EP_GO   = 16'h0010,
        ST_EP_WAIT = 16'h0020,
        ST_RANGE   = 16'h0040,
        ST_CLR_B   = 16'h0080,
        ST_CLR_A   = 16'h0100,
        ST_LV_RD   = 16'h0200,
        ST_LV_B    = 16'h0400,
        ST_LV_BW   = 16'h0800,
        ST_LV_A    = 16'h1000,
        ST_LV_AW   = 16'h2000,
        ST_LV_NX   = 16'h4000,
        ST_RESULT  = 16'h8000
    } state_t;

    typedef struct packed {
        logic [PW-1:0]          bid_price;
        logic [PW-1:0]          ask_price;
        logic signed [NTW-1:0]  bid_net;
        logic signed [NTW-1:0]  ask_net;
    } lvl_t;

    typedef struct packed {
        logic           empty;
        logic           ovf;
        logic [AW-1:0]  from;
        logic [AW-1:0]  to;
    } span_t;

    state_t                 state_reg;
    logic [TW-1:0]          tick_reg;
    logic [plob_pkg::RANGE_W-1:0] range_reg;
    logic [plob_pkg::BLEN_W-1:0]  blen_reg;

    logic [PW-1:0]          lo_reg;
    logic [PW-1:0]          up_reg;
    logic [PW-1:0]          pbb_reg;
    logic [PW-1:0]          pba_reg;
    logic [PW-1:0]          bid0_reg;
    logic [PW-1:0]          ask0_reg;
    logic [PW-1:0]          bout_reg;
    logic [PW-1:0]          aout_reg;
    logic [CW-1:0]          loaded_reg;
    logic                   dropped_reg;

    logic                   is_read_reg;
    logic                   rd_ovf_reg;
    logic                   rd_side_reg;
    logic [AW-1:0]          rd_addr_reg;

    logic [RTW-1:0]         rt_reg;
    logic [1:0]             ep_cnt_reg;
    logic signed [DW-1:0]   ep_reg [4];
    logic                   stop_reg;
    logic                   ovf_reg;
    span_t                  bspan_reg;
    span_t                  aspan_reg;
    logic [AW-1:0]          ptr_reg;
    logic [CW-1:0]          lv_i_reg;

    logic                   rsp_valid_reg;
    logic                   kind_reg;
    logic                   stop_out_reg;
    logic signed [NTW-1:0]  vol_reg;
    logic                   ovf_out_reg;

    lvl_t                   lvl_mem [MAX_LEVELS];
    lvl_t                   lvl_q;
    logic signed [NTW-1:0]  bid_mem [BOOK_DEPTH];
    logic signed [NTW-1:0]  ask_mem [BOOK_DEPTH];
    logic signed [NTW-1:0]  bid_q;
    logic signed [NTW-1:0]  ask_q;

    logic [TW-1:0]          t_w;
    logic [LW-1:0]          len_w;
    logic signed [DW-1:0]   lenm1;
    logic                   req_acc;
    logic                   lvl_we;
    lvl_t                   lvl_wdata;

    logic                   div_start;
    logic [PW-1:0]          div_price;
    logic signed [DW-1:0]   div_num;
    logic                   div_done;
    logic signed [DW-1:0]   quo;
    logic                   quo_ok;

    logic [PW-1:0]          bmax;
    logic [PW-1:0]          amin;
    logic [PW-1:0]          amax;
    logic [PW-1:0]          ep_price;
    logic signed [DW-1:0]   bf;
    logic signed [DW-1:0]   bt;
    logic signed [DW-1:0]   af;
    logic signed [DW-1:0]   at;
    span_t                  bspan;
    span_t                  aspan;
    logic                   stop_w;

    logic signed [DW-1:0]   bid_n;
    logic signed [DW-1:0]   ask_n;
    logic signed [PW:0]     ask_d;
    logic                   bid_cond;
    logic                   ask_cond;

    logic                   bid_we;
    logic                   ask_we;
    logic [AW-1:0]          bid_waddr;
    logic [AW-1:0]          ask_waddr;
    logic signed [NTW-1:0]  bid_wdata;
    logic signed [NTW-1:0]  ask_wdata;
    logic                   slot_free;

    function automatic logic signed [DW-1:0] tick_num(input logic [PW-1:0] p,
                                                      input logic [PW-1:0] lo,
                                                      input logic [TW-1:0] t);
        logic signed [PW:0] d;
        d = $signed({1'b0, p}) - $signed({1'b0, lo});
        return $signed({{2{d[PW]}}, d, 1'b0}) + $signed(DW'(t));
    endfunction

    function automatic span_t clip(input logic signed [DW-1:0] from,
                                   input logic signed [DW-1:0] to,
                                   input logic signed [DW-1:0] last);
        span_t               s;
        logic                none;
        logic signed [DW-1:0] fc;
        logic signed [DW-1:0] tc;
        none    = from > to;
        fc      = (from < 0) ? '0 : from;
        tc      = (to > last) ? last : to;
        s.ovf   = !none && ((from < 0) || (to > last));
        s.empty = none || (fc > tc);
        s.from  = fc[AW-1:0];
        s.to    = tc[AW-1:0];
        return s;
    endfunction

    assign t_w = (tick_reg == '0) ? TW'(1) : tick_reg;

    always_comb
    begin
        if (blen_reg == '0)
            len_w = LW'(1);
        else if (32'(blen_reg) > BOOK_DEPTH)
            len_w = LW'(BOOK_DEPTH);
        else
            len_w = LW'(blen_reg);
    end

    assign lenm1     = $signed(DW'(len_w)) - DW'(1);
    assign req_stall = (state_reg != ST_IDLE);
    assign req_acc   = req_valid && !req_stall;
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    assign lvl_we = req_acc && (mode == plob_pkg::MODE_LEVEL)
                    && (loaded_reg < CW'(MAX_LEVELS));
    assign lvl_wdata.bid_price = bid_price;
    assign lvl_wdata.ask_price = ask_price;
    assign lvl_wdata.bid_net   = $signed({1'b0, bid_volume}) - $signed({1'b0, bid_implied});
    assign lvl_wdata.ask_net   = $signed({1'b0, ask_volume}) - $signed({1'b0, ask_implied});

    assign bmax = (bid0_reg > pbb_reg) ? bid0_reg : pbb_reg;
    assign amin = (ask0_reg < pba_reg) ? ask0_reg : pba_reg;
    assign amax = (ask0_reg > pba_reg) ? ask0_reg : pba_reg;

    always_comb
    begin
        case (ep_cnt_reg)
            2'd0:    ep_price = bout_reg;
            2'd1:    ep_price = bmax;
            2'd2:    ep_price = aout_reg;
            default: ep_price = (amin < PW'(t_w)) ? amax : amin;
        endcase
    end

    // refresh range ends
    always_comb
    begin
        bf = (bout_reg < PW'(t_w)) ? '0 : ((ep_reg[0] < 0) ? '0 : ep_reg[0]);
        bt = (ep_reg[1] < 0) ? '0 : ep_reg[1];
        at = (aout_reg < PW'(t_w)) ? lenm1 : ep_reg[2];
        if ((ask0_reg < PW'(t_w)) && (pba_reg < PW'(t_w)))
            af = lenm1;
        else
            af = ep_reg[3];
        bspan = clip(bf, bt, lenm1);
        aspan = clip(af, at, lenm1);
        stop_w = ({2'b0, bid0_reg} < {2'b0, lo_reg} + (PW+2)'(rt_reg))
                 || ({2'b0, ask0_reg} + (PW+2)'(rt_reg) > {2'b0, up_reg});
    end

    // per level write filters
    assign bid_n    = tick_num(lvl_q.bid_price, lo_reg, t_w);
    assign ask_n    = tick_num(lvl_q.ask_price, lo_reg, t_w);
    assign ask_d    = $signed({1'b0, lvl_q.ask_price}) - $signed({1'b0, up_reg});
    assign bid_cond = ({lvl_q.bid_price, 1'b0} > (PW+1)'(t_w)) && (bid_n > 0);
    assign ask_cond = ({lvl_q.ask_price, 1'b0} > (PW+1)'(t_w))
                      && ($signed({ask_d[PW], ask_d, 1'b0}) < $signed((PW+2)'(t_w)));

    always_comb
    begin
        div_start = 1'b0;
        div_price = ep_price;
        unique case (state_reg)
            ST_EP_GO:
            begin
                div_start = 1'b1;
            end
            ST_LV_B:
            begin
                div_start = bid_cond;
                div_price = lvl_q.bid_price;
            end
            ST_LV_A:
            begin
                div_start = ask_cond;
                div_price = lvl_q.ask_price;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    assign div_num = tick_num(div_price, lo_reg, t_w);

    plob_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   ({t_w, 1'b0}),
        .done  (div_done),
        .quo   (quo)
    );

    assign quo_ok = (quo >= 0) && (quo <= lenm1);

    always_comb
    begin
        bid_we    = 1'b0;
        ask_we    = 1'b0;
        bid_waddr = ptr_reg;
        ask_waddr = ptr_reg;
        bid_wdata = '0;
        ask_wdata = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                bid_we = 1'b1;
                ask_we = 1'b1;
            end
            ST_CLR_B:
            begin
                bid_we = 1'b1;
            end
            ST_CLR_A:
            begin
                ask_we = 1'b1;
            end
            ST_LV_BW:
            begin
                bid_we    = div_done && quo_ok;
                bid_waddr = quo[AW-1:0];
                bid_wdata = lvl_q.bid_net;
            end
            ST_LV_AW:
            begin
                ask_we    = div_done && quo_ok;
                ask_waddr = quo[AW-1:0];
                ask_wdata = lvl_q.ask_net;
            end
            default:
            begin
                bid_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (bid_we)
            bid_mem[bid_waddr] <= bid_wdata;
        bid_q <= bid_mem[rd_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ask_we)
            ask_mem[ask_waddr] <= ask_wdata;
        ask_q <= ask_mem[rd_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (lvl_we)
            lvl_mem[loaded_reg[LAW-1:0]] <= lvl_wdata;
        lvl_q <= lvl_mem[lv_i_reg[LAW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg  <= TW'(1);
            range_reg <= '0;
            blen_reg  <= plob_pkg::BLEN_W'(4096);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                plob_pkg::REG_TICK:   tick_reg  <= cfg_data;
                plob_pkg::REG_RANGE:  range_reg <= cfg_data[plob_pkg::RANGE_W-1:0];
                plob_pkg::REG_LENGTH: blen_reg  <= cfg_data[plob_pkg::BLEN_W-1:0];
                default:              blen_reg  <= blen_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if ((state_reg == ST_RESULT) && slot_free)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            ptr_reg       <= '0;
            lo_reg        <= '0;
            up_reg        <= '0;
            pbb_reg       <= '0;
            pba_reg       <= '0;
            loaded_reg    <= '0;
            dropped_reg   <= 1'b0;
            lv_i_reg      <= '0;
            ep_cnt_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_INIT:
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                    if (ptr_reg == AW'(BOOK_DEPTH - 1))
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (req_acc)
                    begin
                        case (mode)
                            plob_pkg::MODE_HEADER:
                            begin
                                lo_reg      <= lower_limit;
                                up_reg      <= upper_limit;
                                loaded_reg  <= '0;
                                dropped_reg <= 1'b0;
                            end
                            plob_pkg::MODE_LEVEL:
                            begin
                                if (lvl_we)
                                begin
                                    loaded_reg <= loaded_reg + 1'b1;
                                    bout_reg   <= bid_price;
                                    aout_reg   <= ask_price;
                                    if (loaded_reg == '0)
                                    begin
                                        bid0_reg <= bid_price;
                                        ask0_reg <= ask_price;
                                    end
                                end
                                else
                                    dropped_reg <= 1'b1;
                                if (last_level)
                                begin
                                    ovf_reg     <= dropped_reg || !lvl_we;
                                    is_read_reg <= 1'b0;
                                    state_reg   <= ST_PREP;
                                end
                            end
                            plob_pkg::MODE_READ:
                            begin
                                is_read_reg <= 1'b1;
                                rd_side_reg <= read_side;
                                rd_addr_reg <= AW'(read_index);
                                rd_ovf_reg  <= 32'(read_index) >= 32'(len_w);
                                state_reg   <= ST_RD;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_RD:
                begin
                    state_reg <= ST_RESULT;
                end
                ST_PREP:
                begin
                    rt_reg     <= RTW'(range_reg) * RTW'(t_w);
                    ep_cnt_reg <= '0;
                    state_reg  <= ST_EP_GO;
                end
                ST_EP_GO:
                begin
                    state_reg <= ST_EP_WAIT;
                end
                ST_EP_WAIT:
                begin
                    if (div_done)
                    begin
                        ep_reg[ep_cnt_reg] <= quo;
                        ep_cnt_reg <= ep_cnt_reg + 1'b1;
                        state_reg  <= (ep_cnt_reg == 2'd3) ? ST_RANGE : ST_EP_GO;
                    end
                end
                ST_RANGE:
                begin
                    stop_reg  <= stop_w;
                    ovf_reg   <= ovf_reg || bspan.ovf || aspan.ovf;
                    bspan_reg <= bspan;
                    aspan_reg <= aspan;
                    lv_i_reg  <= '0;
                    if (!bspan.empty)
                    begin
                        ptr_reg   <= bspan.from;
                        state_reg <= ST_CLR_B;
                    end
                    else if (!aspan.empty)
                    begin
                        ptr_reg   <= aspan.from;
                        state_reg <= ST_CLR_A;
                    end
                    else
                        state_reg <= ST_LV_RD;
                end
                ST_CLR_B:
                begin
                    if (ptr_reg == bspan_reg.to)
                    begin
                        if (!aspan_reg.empty)
                        begin
                            ptr_reg   <= aspan_reg.from;
                            state_reg <= ST_CLR_A;
                        end
                        else
                            state_reg <= ST_LV_RD;
                    end
                    else
                        ptr_reg <= ptr_reg + 1'b1;
                end
                ST_CLR_A:
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                    if (ptr_reg == aspan_reg.to)
                        state_reg <= ST_LV_RD;
                end
                ST_LV_RD:
                begin
                    state_reg <= ST_LV_B;
                end
                ST_LV_B:
                begin
                    state_reg <= bid_cond ? ST_LV_BW : ST_LV_A;
                end
                ST_LV_BW:
                begin
                    if (div_done)
                    begin
                        if (!quo_ok)
                            ovf_reg <= 1'b1;
                        state_reg <= ST_LV_A;
                    end
                end
                ST_LV_A:
                begin
                    state_reg <= ask_cond ? ST_LV_AW : ST_LV_NX;
                end
                ST_LV_AW:
                begin
                    if (div_done)
                    begin
                        if (!quo_ok)
                            ovf_reg <= 1'b1;
                        state_reg <= ST_LV_NX;
                    end
                end
                ST_LV_NX:
                begin
                    lv_i_reg <= lv_i_reg + 1'b1;
                    if (lv_i_reg + 1'b1 == loaded_reg)
                        state_reg <= ST_RESULT;
                    else
                        state_reg <= ST_LV_RD;
                end
                ST_RESULT:
                begin
                    if (slot_free)
                    begin
                        state_reg <= ST_IDLE;
                        if (is_read_reg)
                        begin
                            kind_reg     <= plob_pkg::KIND_READ;
                            stop_out_reg <= 1'b0;
                            ovf_out_reg  <= rd_ovf_reg;
                            if (rd_ovf_reg)
                                vol_reg <= '0;
                            else
                                vol_reg <= rd_side_reg ? ask_q : bid_q;
                        end
                        else
                        begin
                            kind_reg     <= plob_pkg::KIND_COMMIT;
                            stop_out_reg <= stop_reg;
                            ovf_out_reg  <= ovf_reg;
                            vol_reg      <= '0;
                            pbb_reg      <= bid0_reg;
                            pba_reg      <= ask0_reg;
                            loaded_reg   <= '0;
                            dropped_reg  <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign kind           = kind_reg;
    assign limit_stop     = stop_out_reg;
    assign entry_volume   = vol_reg;
    assign index_overflow = ovf_out_reg;

`ifndef SYNTH
    a_read_no_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && kind == plob_pkg::KIND_READ) |-> !limit_stop)
        else $error("read result carries limit stop");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_EP_WAIT || state_reg == ST_LV_BW
                      || state_reg == ST_LV_AW))
        else $error("divider finished outside a wait state");

    a_bid_write_in_book: assert property (@(posedge clk) disable iff (!rst_n)
        (bid_we && state_reg != ST_INIT) |-> (32'(bid_waddr) < 32'(len_w)))
        else $error("bid ladder write beyond book length");

    a_ask_write_in_book: assert property (@(posedge clk) disable iff (!rst_n)
        (ask_we && state_reg != ST_INIT) |-> (32'(ask_waddr) < 32'(len_w)))
        else $error("ask ladder write beyond book length");
`endif

endmodule

`default_nettype wire

@@ tb/price_ladder_order_book_update_unit_checker.sv @@
`timescale 1ns / 1ps

module price_ladder_order_book_update_unit_checker
    import plob_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [CFG_W-1:0]          cfg_data,
    input  wire logic                      req_valid,
    input  wire logic                      req_stall,
    input  wire logic [1:0]                mode,
    input  wire logic [PRICE_W-1:0]        lower_limit,
    input  wire logic [PRICE_W-1:0]        upper_limit,
    input  wire logic [PRICE_W-1:0]        bid_price,
    input  wire logic [PRICE_W-1:0]        ask_price,
    input  wire logic [VOL_W-1:0]          bid_volume,
    input  wire logic [VOL_W-1:0]          ask_volume,
    input  wire logic [VOL_W-1:0]          bid_implied,
    input  wire logic [VOL_W-1:0]          ask_implied,
    input  wire logic                      last_level,
    input  wire logic                      read_side,
    input  wire logic [IDX_W-1:0]          read_index,
    input  wire logic                      rsp_valid,
    input  wire logic                      rsp_stall,
    input  wire logic                      kind,
    input  wire logic                      limit_stop,
    input  wire logic signed [NET_W-1:0]   entry_volume,
    input  wire logic                      index_overflow,
    output int                             errors,
    output int                             pending
);

    localparam int LEVELS = 32;
    localparam int DEPTH  = 4096;

    typedef struct packed {
        logic                    kind;
        logic                    stop;
        logic signed [NET_W-1:0] vol;
        logic                    ovf;
    } book_rsp_t;

    book_rsp_t expected_rsp[$];

    logic signed [NET_W-1:0] bid_lad [DEPTH];
    logic signed [NET_W-1:0] ask_lad [DEPTH];
    logic [PRICE_W-1:0]      lvl_bid [LEVELS];
    logic [PRICE_W-1:0]      lvl_ask [LEVELS];
    logic signed [NET_W-1:0] lvl_bnet [LEVELS];
    logic signed [NET_W-1:0] lvl_anet [LEVELS];
    int                      lvl_cnt;
    bit                      lvl_dropped;
    logic [PRICE_W-1:0]      snap_lo, snap_up, best_bid_q, best_ask_q;
    logic [TICK_W-1:0]       tick_q;
    logic [RANGE_W-1:0]      range_q;
    logic [BLEN_W-1:0]       blen_q;

    task automatic report(string msg);
        $display("checker: %s at %0t", msg, $realtime);
        errors++;
    endtask

    function automatic longint price_to_idx(longint p, longint t);
        longint d;
        d = p - longint'(snap_lo);
        return (2 * d + t) / (2 * t);
    endfunction

    function automatic void clear_side(bit ask, longint f, longint to, longint len,
                                       inout bit ovf);
        if (f > to) return;
        if (f < 0) begin f = 0; ovf = 1; end
        if (to > len - 1) begin to = len - 1; ovf = 1; end
        for (longint i = f; i <= to; i++) begin
            if (ask) ask_lad[i] = '0;
            else bid_lad[i] = '0;
        end
    endfunction

    function automatic book_rsp_t commit_snapshot();
        longint t, len, lo, up, rt, bid0, ask0, bout, aout, bmax, amin, amax, pbb, pba;
        longint bf, bt, af, at, bp, ap, ix;
        bit ovf, stop;
        book_rsp_t r;
        t   = (tick_q == 0) ? 1 : longint'(tick_q);
        len = (blen_q == 0) ? 1 : (blen_q > DEPTH) ? DEPTH : longint'(blen_q);
        lo  = longint'(snap_lo);
        up  = longint'(snap_up);
        rt  = longint'(range_q) * t;
        bid0 = longint'(lvl_bid[0]);
        ask0 = longint'(lvl_ask[0]);
        bout = longint'(lvl_bid[lvl_cnt-1]);
        aout = longint'(lvl_ask[lvl_cnt-1]);
        pbb  = longint'(best_bid_q);
        pba  = longint'(best_ask_q);
        bmax = (bid0 > pbb) ? bid0 : pbb;
        amin = (ask0 < pba) ? ask0 : pba;
        amax = (ask0 > pba) ? ask0 : pba;
        ovf  = lvl_dropped;
        stop = (bid0 < lo + rt) || (ask0 > up - rt);

        if (bout < t) bf = 0;
        else begin
            bf = price_to_idx(bout, t);
            if (bf < 0) bf = 0;
        end
        bt = price_to_idx(bmax, t);
        if (bt < 0) bt = 0;
        at = (aout < t) ? len - 1 : price_to_idx(aout, t);
        if (ask0 < t && pba < t) af = len - 1;
        else if (amin < t) af = price_to_idx(amax, t);
        else af = price_to_idx(amin, t);

        clear_side(0, bf, bt, len, ovf);
        clear_side(1, af, at, len, ovf);

        for (int i = 0; i < lvl_cnt; i++) begin
            bp = longint'(lvl_bid[i]);
            ap = longint'(lvl_ask[i]);
            if (2 * bp > t && 2 * (bp - lo) > -t) begin
                ix = price_to_idx(bp, t);
                if (ix < 0 || ix >= len) ovf = 1;
                else bid_lad[ix] = lvl_bnet[i];
            end
            if (2 * ap > t && 2 * (ap - up) < t) begin
                ix = price_to_idx(ap, t);
                if (ix < 0 || ix >= len) ovf = 1;
                else ask_lad[ix] = lvl_anet[i];
            end
        end

        best_bid_q  = lvl_bid[0];
        best_ask_q  = lvl_ask[0];
        lvl_cnt     = 0;
        lvl_dropped = 0;
        r.kind = KIND_COMMIT;
        r.stop = stop;
        r.vol  = '0;
        r.ovf  = ovf;
        return r;
    endfunction

    function automatic void take_request();
        book_rsp_t r;
        longint len;
        case (mode)
            MODE_HEADER: begin
                snap_lo     = lower_limit;
                snap_up     = upper_limit;
                lvl_cnt     = 0;
                lvl_dropped = 0;
            end
            MODE_LEVEL: begin
                if (lvl_cnt < LEVELS) begin
                    lvl_bid[lvl_cnt]  = bid_price;
                    lvl_ask[lvl_cnt]  = ask_price;
                    lvl_bnet[lvl_cnt] = $signed({1'b0, bid_volume}) - $signed({1'b0, bid_implied});
                    lvl_anet[lvl_cnt] = $signed({1'b0, ask_volume}) - $signed({1'b0, ask_implied});
                    lvl_cnt++;
                end else begin
                    lvl_dropped = 1;
                end
                if (last_level) expected_rsp.push_back(commit_snapshot());
            end
            MODE_READ: begin
                len = (blen_q == 0) ? 1 : (blen_q > DEPTH) ? DEPTH : longint'(blen_q);
                r.kind = KIND_READ;
                r.stop = 1'b0;
                r.ovf  = longint'(read_index) >= len;
                r.vol  = r.ovf ? '0 : (read_side ? ask_lad[read_index] : bid_lad[read_index]);
                expected_rsp.push_back(r);
            end
            default: ;
        endcase
    endfunction

    initial errors = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                bid_lad[i] = '0;
                ask_lad[i] = '0;
            end
            lvl_cnt     = 0;
            lvl_dropped = 0;
            snap_lo     = '0;
            snap_up     = '0;
            best_bid_q  = '0;
            best_ask_q  = '0;
            tick_q      = 1;
            range_q     = 0;
            blen_q      = 4096;
            expected_rsp.delete();
            pending     = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TICK:   tick_q  = cfg_data[TICK_W-1:0];
                    REG_RANGE:  range_q = cfg_data[RANGE_W-1:0];
                    REG_LENGTH: blen_q  = cfg_data[BLEN_W-1:0];
                    default: ;
                endcase
            end
            if (req_valid && !req_stall) take_request();
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp.size() == 0)
                    report("response with no request outstanding");
                else
                begin
                    book_rsp_t e;
                    e = expected_rsp.pop_front();
                    if (kind !== e.kind)
                        report($sformatf("kind %0b, want %0b", kind, e.kind));
                    if (limit_stop !== e.stop)
                        report($sformatf("limit_stop %0b, want %0b", limit_stop, e.stop));
                    if (entry_volume !== e.vol)
                        report($sformatf("entry_volume %0d, want %0d", entry_volume, e.vol));
                    if (index_overflow !== e.ovf)
                        report($sformatf("index_overflow %0b, want %0b", index_overflow,
                                         e.ovf));
                end
            end
            pending = expected_rsp.size();
        end
    end

endmodule

@@ tb/price_ladder_order_book_update_unit_tb.sv @@
`timescale 1ns / 1ps

module price_ladder_order_book_update_unit_tb;
    import plob_pkg::*;

    typedef struct packed {
        logic [1:0]         mode;
        logic [PRICE_W-1:0] lo;
        logic [PRICE_W-1:0] up;
        logic [PRICE_W-1:0] bp;
        logic [PRICE_W-1:0] ap;
        logic [VOL_W-1:0]   bv;
        logic [VOL_W-1:0]   av;
        logic [VOL_W-1:0]   bi;
        logic [VOL_W-1:0]   ai;
        logic               last;
        logic               side;
        logic [IDX_W-1:0]   idx;
    } quote_req_t;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [1:0] cfg_index = REG_TICK;
    logic [CFG_W-1:0] cfg_data = '0;
    logic req_valid = 0;
    logic rsp_stall = 0;
    quote_req_t cur = '0;
    wire logic req_stall, rsp_valid, kind, limit_stop, index_overflow;
    wire logic signed [NET_W-1:0] entry_volume;
    int errors, pending;
    int burst_left = 0;
    bit hold_req = 0;

    always #5 clk = ~clk;

    price_ladder_order_book_update_unit u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .req_valid(req_valid), .req_stall(req_stall),
        .mode(cur.mode), .lower_limit(cur.lo), .upper_limit(cur.up),
        .bid_price(cur.bp), .ask_price(cur.ap), .bid_volume(cur.bv),
        .ask_volume(cur.av), .bid_implied(cur.bi), .ask_implied(cur.ai),
        .last_level(cur.last), .read_side(cur.side), .read_index(cur.idx),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .kind(kind),
        .limit_stop(limit_stop), .entry_volume(entry_volume),
        .index_overflow(index_overflow)
    );

    price_ladder_order_book_update_unit_checker u_chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .req_valid(req_valid), .req_stall(req_stall),
        .mode(cur.mode), .lower_limit(cur.lo), .upper_limit(cur.up),
        .bid_price(cur.bp), .ask_price(cur.ap), .bid_volume(cur.bv),
        .ask_volume(cur.av), .bid_implied(cur.bi), .ask_implied(cur.ai),
        .last_level(cur.last), .read_side(cur.side), .read_index(cur.idx),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .kind(kind),
        .limit_stop(limit_stop), .entry_volume(entry_volume),
        .index_overflow(index_overflow), .errors(errors), .pending(pending)
    );

    // receiver: random stall patterns, plus one long hold-off on request
    initial
    begin
        int n, pat;
        forever
        begin
            if (hold_req)
            begin
                hold_req = 0;
                rsp_stall <= 1;
                for (int c = 0; c < 3000; c++) @(posedge clk);
            end
            else
            begin
                pat = $urandom_range(0, 3);
                n = $urandom_range(1, 50);
                for (int c = 0; c < n; c++)
                begin
                    case (pat)
                        0: rsp_stall <= 0;
                        1: rsp_stall <= $urandom_range(0, 1);
                        2: rsp_stall <= (c < 8);
                        default: rsp_stall <= c[0];
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        #300_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic push(quote_req_t r);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                req_valid <= 0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        cur <= r;
        req_valid <= 1;
        @(negedge clk);
        while (req_stall)
        begin
            @(posedge clk);
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    // drain all results, then allow for a trailing request with no result
    task automatic drain();
        req_valid <= 0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] v);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    function automatic quote_req_t read_req(logic side, logic [IDX_W-1:0] idx);
        quote_req_t r;
        r = quote_req_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom});
        r.mode = MODE_READ;
        r.side = side;
        r.idx = idx;
        return r;
    endfunction

    function automatic quote_req_t level_req(longint bp, longint ap, logic last);
        quote_req_t r;
        r = read_req(0, 0);
        r.mode = MODE_LEVEL;
        r.bp = bp;
        r.ap = ap;
        r.last = last;
        if ($urandom_range(0, 9) == 0) r.bv = '1;
        if ($urandom_range(0, 9) == 0) r.av = '0;
        if ($urandom_range(0, 3) != 0) r.bi = r.bv >> $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) r.ai = r.av >> $urandom_range(1, 24);
        return r;
    endfunction

    function automatic longint ladder_price(longint base, longint ix, longint t);
        longint p;
        int sel;
        p = base + ix * t;
        sel = $urandom_range(0, 7);
        if (sel == 0) p += t / 2;
        else if (sel == 1) p -= t / 2;
        else if (sel == 2) p += longint'($urandom_range(0, 32'hFFFF_FFFF)) % t;
        if (p < 0) p = 0;
        if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
        if ($urandom_range(0, 11) == 0) p = 0;
        return p;
    endfunction

    // one header, its levels and a few reads; returns the request count
    task automatic snapshot(longint t, longint len, output int cnt);
        quote_req_t r;
        longint lo, span, mid;
        int nlev, sel;
        r = read_req(0, 0);
        lo = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 32'hFFFF_FFFF - 700 * t);
        span = $urandom_range(1, (len < 300) ? len + 2 : 300);
        mid = $urandom_range(0, span);
        r.mode = MODE_HEADER;
        r.lo = lo;
        r.up = ($urandom_range(0, 15) == 0) ? 64'hFFFF_FFFF : lo + span * t;
        push(r);
        sel = $urandom_range(0, 19);
        nlev = (sel < 16) ? $urandom_range(1, 6) : (sel < 18) ? $urandom_range(7, 32)
                                                             : $urandom_range(33, 36);
        for (int k = 0; k < nlev; k++)
            push(level_req(ladder_price(lo, mid - k, t), ladder_price(lo, mid + 1 + k, t),
                           k == nlev - 1));
        cnt = nlev + 1;
        for (int k = $urandom_range(1, 4); k > 0; k--)
        begin
            push(read_req($urandom_range(0, 1),
                 ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4095)
                                             : $urandom_range(0, span + 4)));
            cnt++;
        end
    endtask

    logic [CFG_W-1:0] ph_tick [8] = '{1, 0, 7, 1000000, 1048575, 3, 250, 1};
    logic [CFG_W-1:0] ph_rng  [8] = '{0, 255, 5, 17, 0, 100, 1, 3};
    logic [CFG_W-1:0] ph_len  [8] = '{64, 0, 200, 8191, 4096, 1, 17, 300};

    initial
    begin
        quote_req_t r;
        longint t, len;
        int sent, cnt, budget;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: reset config, empty ladders, odd modes, extremes
        push(read_req(0, 0));
        push(read_req(1, 4095));
        r = read_req(0, 0); r.mode = 2'd3; push(r);
        push(level_req(5, 9, 1));                 // no header seen yet
        r = read_req(0, 0); r.mode = MODE_HEADER; r.lo = 100; r.up = 300; push(r);
        r = level_req(150, 160, 0); r.bv = '1; r.bi = '0; push(r);
        r = level_req(149, 161, 0); r.bv = '0; r.bi = '1; push(r);
        push(level_req(0, 0, 1));
        push(read_req(0, 50));
        push(read_req(1, 60));
        push(read_req(0, 49));
        r = read_req(0, 0); r.mode = MODE_HEADER; r.lo = 0; r.up = '1; push(r);
        r = level_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1); r.bv = '0; r.ai = '1; push(r);
        r = read_req(0, 0); r.mode = MODE_HEADER; r.lo = '1; r.up = 0; push(r);
        push(level_req(1, 2, 1));
        push(read_req(1, 4095));
        push(read_req(0, 4095));
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(REG_TICK, ph_tick[ph]);
            write_reg(REG_RANGE, ph_rng[ph]);
            write_reg(REG_LENGTH, ph_len[ph]);
            t = (ph_tick[ph] == 0) ? 1 : ph_tick[ph];
            len = (ph_len[ph] == 0) ? 1 : (ph_len[ph] > 4096) ? 4096 : ph_len[ph];
            budget = (len >= 4096) ? 80 : 190;
            sent = 0;
            if (ph == 2)
            begin
                hold_req = 1;
                for (int k = 0; k < 16; k++) push(read_req(k[0], k));
                sent = 16;
            end
            while (sent < budget)
            begin
                if (len < 4096 && $urandom_range(0, 15) == 0)
                begin
                    r = read_req(0, 0);
                    r = quote_req_t'({r[$bits(quote_req_t)-1:2], 2'b00} ^
                                     {$urandom, $urandom, $urandom, $urandom, $urandom,
                                      $urandom, $urandom, $urandom, $urandom});
                    push(r);
                    sent++;
                end
                else
                begin
                    snapshot(t, len, cnt);
                    sent += cnt;
                end
            end
            drain();
        end

        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/plob_pkg.sv
rtl/plob_div.sv
rtl/price_ladder_order_book_update_unit.sv
tb/price_ladder_order_book_update_unit_checker.sv
tb/price_ladder_order_book_update_unit_tb.sv
